@@ rtl/h2d_pkg.sv @@
// ----------------------------------------------------------------------------
// h2d_pkg
// Shared types and constants for the two-dimensional histogram binner.
// ----------------------------------------------------------------------------
`default_nettype none

package h2d_pkg;

  localparam int DATA_W    = 32;   // sample, origin, step and reported count
  localparam int USED_W    = 7;    // bins-in-use registers
  localparam int RIDX_W    = 6;    // read index fields
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  typedef logic [OP_W-1:0] opcode_t;

  localparam opcode_t OP_COUNT = 2'd0;
  localparam opcode_t OP_READ  = 2'd1;
  localparam opcode_t OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_INV_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_USED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_INV_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_USED     = 3'd5;

  localparam logic [DATA_W-1:0] RST_ORIGIN   = 32'd0;
  localparam logic [DATA_W-1:0] RST_INV_STEP = 32'd65536;
  localparam logic [USED_W-1:0] RST_USED     = 7'd64;

  // one half in Q32.32
  localparam logic [2*DATA_W:0] HALF_Q32 = 65'h0_8000_0000;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input item
    logic rd;       // read the addressed bin
    logic report;   // write back (count) and load the result registers
    logic clr;      // zero the bin at the clear pointer and advance it
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    clr_last;
  } ctl_stat_t;

endpackage

`default_nettype wire

@@ rtl/histogram_2d_binner.sv @@
// Count, read and unused-opcode items: each passes the axis pipeline and a bin
//   read-modify-write; the next item is taken only once the last is done (busy low).
// Clear item: a sweep that zeroes the store, one bin per cycle.
// Reset (synchronous, rst_n low): a sweep over all MAX_X_BINS*MAX_Y_BINS bins (4096 by
//   default) zeroes the store with busy high; config writes are taken meanwhile.
// Results are held for exactly one cycle on out_strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// histogram_2d_binner
// Two-dimensional histogram with rounded Q16.16 binning, saturating counters,
// bin read-back and full clear.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_2d_binner #(
  parameter int MAX_X_BINS  = 64,
  parameter int MAX_Y_BINS  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [h2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [h2d_pkg::DATA_W-1:0]        cfg_data,
  input  wire                               start,
  output logic                              busy,
  input  wire  [h2d_pkg::OP_W-1:0]          in_opcode,
  input  wire  [h2d_pkg::DATA_W-1:0]        in_x_value,
  input  wire  [h2d_pkg::DATA_W-1:0]        in_y_value,
  input  wire  [h2d_pkg::RIDX_W-1:0]        in_x_index,
  input  wire  [h2d_pkg::RIDX_W-1:0]        in_y_index,
  output logic                              out_strobe,
  output logic                              out_accepted,
  output logic [h2d_pkg::DATA_W-1:0]        out_bin_count
);

  h2d_pkg::ctl_cmd_t  cmd;
  h2d_pkg::ctl_stat_t stat;

  h2d_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  h2d_datapath #(
    .MAX_X_BINS  (MAX_X_BINS),
    .MAX_Y_BINS  (MAX_Y_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_opcode     (in_opcode),
    .in_x_value    (in_x_value),
    .in_y_value    (in_y_value),
    .in_x_index    (in_x_index),
    .in_y_index    (in_y_index),
    .cmd           (cmd),
    .stat          (stat),
    .out_strobe    (out_strobe),
    .out_accepted  (out_accepted),
    .out_bin_count (out_bin_count)
  );

endmodule

`default_nettype wire

@@ rtl/h2d_axis.sv @@
// ----------------------------------------------------------------------------
// h2d_axis
// One axis of bin index computation: floor((value - origin) * inv + 1/2),
// three register stages, with the range test against the bins in use.
// ----------------------------------------------------------------------------
`default_nettype none

module h2d_axis #(
  parameter int MAX_BINS = 64,
  localparam int IW = $clog2(MAX_BINS)
) (
  input  wire                                 clk,
  input  wire  [h2d_pkg::DATA_W-1:0]          value,
  input  wire  [h2d_pkg::DATA_W-1:0]          origin,
  input  wire  [h2d_pkg::DATA_W-1:0]          inv_step,
  input  wire  [h2d_pkg::USED_W-1:0]          bins_used,
  output logic [IW-1:0]                       idx,
  output logic                                ok
);

  localparam int DW = h2d_pkg::DATA_W;

  logic signed [DW:0]   diff;
  logic [DW-1:0]        mag_nxt;
  logic [DW-1:0]        mag_r;
  logic                 neg_r;
  logic [2*DW-1:0]      prod_nxt;
  logic [2*DW-1:0]      prod_r;
  logic                 neg2_r;
  logic [2*DW:0]        sum;
  logic [DW:0]          whole;
  logic [DW:0]          lim;
  logic                 ok_nxt;
  logic [IW-1:0]        idx_nxt;
  logic [IW-1:0]        idx_r;
  logic                 ok_r;

  // stage 1: exact 33-bit difference, split into sign and magnitude
  always_comb begin
    diff    = $signed({value[DW-1], value}) - $signed({origin[DW-1], origin});
    mag_nxt = diff[DW] ? DW'(-diff) : diff[DW-1:0];
  end

  // stage 2: 32x32 product, Q32.32
  assign prod_nxt = {{DW{1'b0}}, mag_r} * {{DW{1'b0}}, inv_step};

  // stage 3: round and range check
  always_comb begin
    sum   = {1'b0, prod_r} + h2d_pkg::HALF_Q32;
    whole = sum[2*DW:DW];
    lim   = ((DW+1)'(bins_used) < (DW+1)'(MAX_BINS)) ? (DW+1)'(bins_used)
                                                     : (DW+1)'(MAX_BINS);
    if (neg2_r) begin
      // negative offset lands in bin zero only within half a bin
      ok_nxt  = (prod_r <= h2d_pkg::HALF_Q32[2*DW-1:0]) && (lim != '0);
      idx_nxt = '0;
    end else begin
      ok_nxt  = whole < lim;
      idx_nxt = whole[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= diff[DW];
    prod_r <= prod_nxt;
    neg2_r <= neg_r;
    idx_r  <= idx_nxt;
    ok_r   <= ok_nxt;
  end

  assign idx = idx_r;
  assign ok  = ok_r;

endmodule

`default_nettype wire

@@ rtl/h2d_datapath.sv @@
// ----------------------------------------------------------------------------
// h2d_datapath
// Configuration registers, input capture, both axis units, the bin store
// with its clear pointer, and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module h2d_datapath #(
  parameter int MAX_X_BINS  = 64,
  parameter int MAX_Y_BINS  = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire  [h2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [h2d_pkg::DATA_W-1:0]           cfg_data,
  input  wire  [h2d_pkg::OP_W-1:0]             in_opcode,
  input  wire  [h2d_pkg::DATA_W-1:0]           in_x_value,
  input  wire  [h2d_pkg::DATA_W-1:0]           in_y_value,
  input  wire  [h2d_pkg::RIDX_W-1:0]           in_x_index,
  input  wire  [h2d_pkg::RIDX_W-1:0]           in_y_index,
  input  wire  h2d_pkg::ctl_cmd_t              cmd,
  output h2d_pkg::ctl_stat_t                   stat,
  output logic                                 out_strobe,
  output logic                                 out_accepted,
  output logic [h2d_pkg::DATA_W-1:0]           out_bin_count
);

  localparam int DW    = h2d_pkg::DATA_W;
  localparam int DEPTH = MAX_X_BINS * MAX_Y_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_X_BINS);
  localparam int YW    = $clog2(MAX_Y_BINS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration
  logic [DW-1:0]                 x_origin_r, x_inv_step_r, y_origin_r, y_inv_step_r;
  logic [h2d_pkg::USED_W-1:0]    x_used_r, y_used_r;

  // captured item
  h2d_pkg::opcode_t              op_r;
  logic [DW-1:0]                 x_value_r, y_value_r;
  logic [h2d_pkg::RIDX_W-1:0]    x_index_r, y_index_r;

  logic [XW-1:0]                 x_bin;
  logic [YW-1:0]                 y_bin;
  logic                          x_ok, y_ok;

  logic [XW-1:0]                 x_sel;
  logic [YW-1:0]                 y_sel;
  logic [AW-1:0]                 addr;
  logic                          rd_ok;
  logic                          rd_ok_r;
  logic [AW-1:0]                 clr_ptr_r;
  logic [COUNT_WIDTH-1:0]        bin_mem_r [DEPTH];
  logic [COUNT_WIDTH-1:0]        rd_data_r;
  logic [COUNT_WIDTH-1:0]        inc_data;
  logic                          cnt_we;
  logic [63:0]                   rd_wide;
  logic [DW-1:0]                 rd_sat;
  logic                          acc_nxt;
  logic [DW-1:0]                 cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r   <= h2d_pkg::RST_ORIGIN;
      x_inv_step_r <= h2d_pkg::RST_INV_STEP;
      x_used_r     <= h2d_pkg::RST_USED;
      y_origin_r   <= h2d_pkg::RST_ORIGIN;
      y_inv_step_r <= h2d_pkg::RST_INV_STEP;
      y_used_r     <= h2d_pkg::RST_USED;
    end else if (cfg_we) begin
      case (cfg_index)
        h2d_pkg::CFG_X_ORIGIN:   x_origin_r   <= cfg_data;
        h2d_pkg::CFG_X_INV_STEP: x_inv_step_r <= cfg_data;
        h2d_pkg::CFG_X_USED:     x_used_r     <= cfg_data[h2d_pkg::USED_W-1:0];
        h2d_pkg::CFG_Y_ORIGIN:   y_origin_r   <= cfg_data;
        h2d_pkg::CFG_Y_INV_STEP: y_inv_step_r <= cfg_data;
        h2d_pkg::CFG_Y_USED:     y_used_r     <= cfg_data[h2d_pkg::USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      x_value_r <= in_x_value;
      y_value_r <= in_y_value;
      x_index_r <= in_x_index;
      y_index_r <= in_y_index;
    end
  end

  h2d_axis #(.MAX_BINS(MAX_X_BINS)) u_x_axis (
    .clk       (clk),
    .value     (x_value_r),
    .origin    (x_origin_r),
    .inv_step  (x_inv_step_r),
    .bins_used (x_used_r),
    .idx       (x_bin),
    .ok        (x_ok)
  );

  h2d_axis #(.MAX_BINS(MAX_Y_BINS)) u_y_axis (
    .clk       (clk),
    .value     (y_value_r),
    .origin    (y_origin_r),
    .inv_step  (y_inv_step_r),
    .bins_used (y_used_r),
    .idx       (y_bin),
    .ok        (y_ok)
  );

  // bin (x,y) lives at x*MAX_Y_BINS + y
  always_comb begin
    rd_ok = (32'(x_index_r) < 32'(MAX_X_BINS)) && (32'(y_index_r) < 32'(MAX_Y_BINS));
    if (op_r == h2d_pkg::OP_READ) begin
      x_sel = XW'(x_index_r);
      y_sel = YW'(y_index_r);
    end else begin
      x_sel = x_bin;
      y_sel = y_bin;
    end
    addr = AW'(32'(x_sel) * 32'(MAX_Y_BINS) + 32'(y_sel));
  end

  assign inc_data = (rd_data_r == CNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
  assign cnt_we   = cmd.report && (op_r == h2d_pkg::OP_COUNT) && x_ok && y_ok;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      bin_mem_r[clr_ptr_r] <= '0;
    end else if (cnt_we) begin
      bin_mem_r[addr] <= inc_data;
    end
    if (cmd.rd) begin
      rd_data_r <= bin_mem_r[addr];
      rd_ok_r   <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
    end else if (cmd.clr) begin
      clr_ptr_r <= stat.clr_last ? '0 : clr_ptr_r + 1'b1;
    end
  end

  assign stat.op       = op_r;
  assign stat.clr_last = (clr_ptr_r == AW'(DEPTH - 1));

  // reported count saturates at 32 bits for wide counters
  always_comb begin
    rd_wide = 64'(rd_data_r);
    rd_sat  = (|rd_wide[63:DW]) ? {DW{1'b1}} : rd_wide[DW-1:0];
    acc_nxt = (op_r == h2d_pkg::OP_COUNT) && x_ok && y_ok;
    cnt_nxt = ((op_r == h2d_pkg::OP_READ) && rd_ok_r) ? rd_sat : '0;
  end

  logic          strobe_r;
  logic          acc_r;
  logic [DW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.report;
    end
    if (cmd.report) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_accepted  = acc_r;
  assign out_bin_count = cnt_r;

endmodule

`default_nettype wire

@@ rtl/h2d_ctrl.sv @@
// ----------------------------------------------------------------------------
// h2d_ctrl
// Sequencer: clear sweep after reset, index pipeline timing, bin
// read-modify-write and the clear command sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module h2d_ctrl (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire  h2d_pkg::ctl_stat_t   stat,
  output h2d_pkg::ctl_cmd_t          cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;  // sweep after reset, no result
  localparam logic [2:0] ST_CLEAR = 3'd2;  // sweep for a clear item
  localparam logic [2:0] ST_MAG   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_IDX   = 3'd5;
  localparam logic [2:0] ST_RD    = 3'd6;
  localparam logic [2:0] ST_WB    = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MAG;
        end
      end
      ST_INIT: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_MAG: begin
        state_nxt = (stat.op == h2d_pkg::OP_CLEAR) ? ST_CLEAR : ST_MUL;
      end
      ST_MUL: state_nxt = ST_IDX;
      ST_IDX: state_nxt = ST_RD;
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.report = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire
